@@ src/rbm_pkg.sv @@
// ----------------------------------------------------------------------------
// rbm_pkg
// Shared types and constants for the cartridge bank mapper.
// ----------------------------------------------------------------------------
`default_nettype none

package rbm_pkg;

	// field widths
	localparam int unsigned OP_W       = 2;
	localparam int unsigned ADDR_W     = 22;
	localparam int unsigned DATA_W     = 8;
	localparam int unsigned TADDR_W    = 23;
	localparam int unsigned PAGE_W     = 4;
	localparam int unsigned NUM_BANKS  = 7;
	localparam int unsigned BANK_OFS_W = 19;

	// default shift of a page number into the ROM address
	localparam int unsigned PAGE_BITS_DEF = 19;

	// reset value of the ROM mask
	localparam logic [TADDR_W-1:0] ROM_MASK_RST = 23'h7f_ffff;

	// bus item kinds
	typedef enum logic [OP_W-1:0] {
		OP_REG_WR = 2'd0,
		OP_READ   = 2'd1,
		OP_WRITE  = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	// result target kinds
	typedef enum logic [1:0] {
		TGT_ROM  = 2'd0,
		TGT_SRAM = 2'd1,
		TGT_PCM  = 2'd2,
		TGT_NONE = 2'd3
	} target_t;

	// mapper register indexes
	localparam logic [3:0] REG_CTRL = 4'h0;
	localparam logic [3:0] REG_LAST = 4'hf;

	// control register bits
	localparam int unsigned CTRL_UNLOCK_BIT = 7;
	localparam int unsigned CTRL_WREN_BIT   = 5;

	// last bank overlay selections
	localparam logic [DATA_W-1:0] SEL_SRAM     = 8'h80;
	localparam logic [DATA_W-1:0] SEL_PCM      = 8'h81;
	localparam logic [DATA_W-1:0] LAST_SEL_RST = 8'h07;

	// mapper state seen by the translator
	typedef struct packed {
		logic [NUM_BANKS-1:0][PAGE_W-1:0] bank_page;
		logic                             bank0_unlocked;
		logic                             write_en;
		logic [DATA_W-1:0]                last_sel;
	} map_state_t;

endpackage

`default_nettype wire

@@ src/rbm_regs.sv @@
// ----------------------------------------------------------------------------
// rbm_regs
// Mapper register file: bank pages, bank 0 lock, write enable, last bank select.
// ----------------------------------------------------------------------------
`default_nettype none

module rbm_regs
	import rbm_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              wr_en,
	input  wire logic [3:0]        reg_sel,
	input  wire logic [DATA_W-1:0] wr_data,
	output map_state_t             map
);

	logic [NUM_BANKS-1:0][PAGE_W-1:0] bank_page_q;
	logic                             bank0_unlocked_q;
	logic                             write_en_q;
	logic [DATA_W-1:0]                last_sel_q;
	logic [2:0]                       bank_idx;
	logic                             page_wr;

	// odd registers 1 to 13 address banks 0 to 6; bank 0 only while unlocked
	always_comb begin
		bank_idx = reg_sel[3:1];
		page_wr  = wr_en && reg_sel[0] && (reg_sel != REG_LAST)
		           && ((bank_idx != 3'd0) || bank0_unlocked_q);
	end

	// register updates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_BANKS; i++) begin
				bank_page_q[i] <= PAGE_W'(i);
			end
			bank0_unlocked_q <= 1'b0;
			write_en_q       <= 1'b0;
			last_sel_q       <= LAST_SEL_RST;
		end else if (wr_en) begin
			if (reg_sel == REG_CTRL) begin
				bank0_unlocked_q <= wr_data[CTRL_UNLOCK_BIT];
				write_en_q       <= wr_data[CTRL_UNLOCK_BIT] & wr_data[CTRL_WREN_BIT];
			end else if (reg_sel == REG_LAST) begin
				last_sel_q <= wr_data;
			end else if (page_wr) begin
				bank_page_q[bank_idx] <= wr_data[PAGE_W-1:0];
			end
		end
	end

	assign map.bank_page      = bank_page_q;
	assign map.bank0_unlocked = bank0_unlocked_q;
	assign map.write_en       = write_en_q;
	assign map.last_sel       = last_sel_q;

endmodule

`default_nettype wire

@@ src/rbm_xlate.sv @@
// ----------------------------------------------------------------------------
// rbm_xlate
// Address translation of one bus item against the current mapper state.
// ----------------------------------------------------------------------------
`default_nettype none

module rbm_xlate
	import rbm_pkg::*;
#(
	parameter int unsigned PAGE_BITS = PAGE_BITS_DEF
)(
	input  wire logic [OP_W-1:0]    op,
	input  wire logic [ADDR_W-1:0]  address,
	input  wire map_state_t         map,
	input  wire logic [TADDR_W-1:0] rom_mask,
	output target_t                 target,
	output logic [TADDR_W-1:0]      target_address,
	output logic                    allowed
);

	localparam int unsigned SUM_W = PAGE_W + PAGE_BITS + 1;

	logic [2:0]        bank;
	logic [PAGE_W-1:0] page;
	logic [SUM_W-1:0]  rom_sum;
	logic [TADDR_W-1:0] rom_addr;
	logic              is_xlate;

	// page for the addressed bank; locked bank 0 shows page 0
	always_comb begin
		bank = address[ADDR_W-1:BANK_OFS_W];
		if (bank == 3'd7) begin
			page = map.last_sel[PAGE_W-1:0];
		end else if ((bank == 3'd0) && !map.bank0_unlocked) begin
			page = '0;
		end else begin
			page = map.bank_page[bank];
		end
		rom_sum  = (SUM_W'(page) << PAGE_BITS) + SUM_W'(address[BANK_OFS_W-1:0]);
		rom_addr = TADDR_W'(rom_sum) & rom_mask;
	end

	// target selection
	always_comb begin
		is_xlate       = (op == OP_READ) || (op == OP_WRITE);
		target         = TGT_NONE;
		target_address = '0;
		allowed        = 1'b0;
		if (is_xlate) begin
			allowed = (op == OP_READ) || map.write_en;
			if (bank != 3'd7) begin
				target         = TGT_ROM;
				target_address = rom_addr;
			end else if (map.last_sel == SEL_SRAM) begin
				target         = TGT_SRAM;
				target_address = TADDR_W'(address[15:0]);
			end else if (map.last_sel == SEL_PCM) begin
				target         = TGT_PCM;
				target_address = TADDR_W'(address[13:1]);
			end else begin
				target         = TGT_ROM;
				target_address = rom_addr;
			end
		end
	end

endmodule

`default_nettype wire

@@ src/rom_bank_mapper_with_overlays_unit.sv @@
// ----------------------------------------------------------------------------
// rom_bank_mapper_with_overlays_unit
// Cartridge bank mapper with SRAM and PCM overlays on the last 512K bank.
// ----------------------------------------------------------------------------
// Takes one bus item per clock while the output is not stalled and returns one
// result per item. Items pass an input register and a result register with the
// translation between them; a mapper register write updates the mapper state as
// it leaves the input register, so the very next item already sees it. rom_mask
// may be written only while idle.
`default_nettype none

module rom_bank_mapper_with_overlays_unit
	import rbm_pkg::*;
#(
	parameter int unsigned PAGE_BITS = PAGE_BITS_DEF
)(
	input  wire logic               clk,
	input  wire logic               arst_n,
	// configuration
	input  wire logic               cfg_write,
	input  wire logic [TADDR_W-1:0] cfg_wdata,
	// input channel
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [OP_W-1:0]    op,
	input  wire logic [ADDR_W-1:0]  address,
	input  wire logic [DATA_W-1:0]  data,
	// output channel
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [1:0]              target,
	output logic [TADDR_W-1:0]      target_address,
	output logic                    allowed
);

	logic [TADDR_W-1:0] rom_mask_q;
	logic               valid_s1;
	logic [OP_W-1:0]    op_s1;
	logic [ADDR_W-1:0]  address_s1;
	logic [DATA_W-1:0]  data_s1;
	logic               valid_s2;
	target_t            target_s2;
	logic [TADDR_W-1:0] target_address_s2;
	logic               allowed_s2;
	logic               advance;
	logic               in_xfer;
	logic               reg_wr;
	map_state_t         map;
	target_t            xl_target;
	logic [TADDR_W-1:0] xl_address;
	logic               xl_allowed;

	// flow control
	assign advance  = !valid_s2 || !out_stall;
	assign in_stall = valid_s1 && !advance;
	assign in_xfer  = in_valid && !in_stall;
	assign reg_wr   = valid_s1 && advance && (op_s1 == OP_REG_WR);

	// rom mask register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rom_mask_q <= ROM_MASK_RST;
		end else if (cfg_write) begin
			rom_mask_q <= cfg_wdata;
		end
	end

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			op_s1      <= op;
			address_s1 <= address;
			data_s1    <= data;
		end
	end

	// mapper state
	rbm_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (reg_wr),
		.reg_sel (address_s1[3:0]),
		.wr_data (data_s1),
		.map     (map)
	);

	// translation
	rbm_xlate #(
		.PAGE_BITS (PAGE_BITS)
	) u_xlate (
		.op             (op_s1),
		.address        (address_s1),
		.map            (map),
		.rom_mask       (rom_mask_q),
		.target         (xl_target),
		.target_address (xl_address),
		.allowed        (xl_allowed)
	);

	// result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			target_s2         <= xl_target;
			target_address_s2 <= xl_address;
			allowed_s2        <= xl_allowed;
		end
	end

	assign out_valid      = valid_s2;
	assign target         = target_s2;
	assign target_address = target_address_s2;
	assign allowed        = allowed_s2;

	// an item held in the input stage stays there
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1)
		else $error("input stage item lost while stalled");

	// input side only stalls with a full input stage
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && valid_s2 && out_stall)
		else $error("input stalled without a full pipeline");

	// register writes and ignored items are never permitted
	a_none_denied: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (target == TGT_NONE) |-> !allowed && (target_address == '0))
		else $error("non-access result carries access fields");

	// pcm register index stays within its window
	a_pcm_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (target == TGT_PCM) |-> (target_address[TADDR_W-1:13] == '0))
		else $error("pcm register index out of range");

endmodule

`default_nettype wire
